// ===== rtl/core/sdaf_pkg.sv =====
// Shared constants and types for the signed decimal ASCII formatter.
package sdaf_pkg;

	localparam int SDAF_VALUE_BITS = 16;
	localparam int SDAF_STEP_BITS  = 2;
	localparam int SDAF_FRAC_DIGITS = 2;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_POINT = 8'h2E;

	localparam logic KIND_INT  = 1'b0;
	localparam logic KIND_HUND = 1'b1;

	typedef struct packed {
		logic valid;
		logic neg;
		logic kind;
	} sdaf_ctl_t;

endpackage

// ===== rtl/core/signed_decimal_ascii_formatter_core.sv =====
// Top level of the signed decimal ASCII formatter.
//
// Input stream: s_tdata carries a two's complement value, s_tuser selects
// integer (0) or fixed point hundredths (1). Output stream: one ASCII
// character per word on m_tdata, most significant first; m_tlast marks the
// final character of each number. Negative values get a leading '-', the
// most negative code saturates to one above it. Hundredths output always
// has a '.' and two fraction digits.
// Conversion runs in the serial BCD shifter after the number is accepted.
// Character output loads the digits and then gives one character per
// cycle while the output is not stalled (up to 7 characters at 16 bits).
// The two parts overlap, so a new number can be taken while the previous
// one is still being output.
// When m_tready is low the output word holds and the sequencer waits; the
// converter then holds its result and s_tready drops until it is handed on.
// Reset clears the state machines and the output valid; no words are in flight afterwards.
module signed_decimal_ascii_formatter_core #(
	parameter int VALUE_BITS = sdaf_pkg::SDAF_VALUE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,  // value
	input  logic                              s_tuser,  // kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,  // char_code
	output logic                              m_tlast   // last_char
);
	import sdaf_pkg::*;

	localparam int MAG_BITS = VALUE_BITS - 1;
	localparam int DIGITS   = ((MAG_BITS * 77) / 256) + 1;

	logic [VALUE_BITS-1:0] raw;
	logic                  neg;
	logic [MAG_BITS-1:0]   negated;
	logic [MAG_BITS-1:0]   mag;
	logic                  take;
	sdaf_ctl_t             ctl;
	logic [DIGITS*4-1:0]   digits;

	assign raw     = s_tdata[VALUE_BITS-1:0];
	assign neg     = raw[VALUE_BITS-1];
	assign negated = (~raw[MAG_BITS-1:0]) + 1'b1;
	// most negative code: low bits negate to zero, saturate to all ones
	assign mag = !neg ? raw[MAG_BITS-1:0] :
		(negated == '0) ? {MAG_BITS{1'b1}} : negated;

	sdaf_bcd #(
		.VALUE_BITS(VALUE_BITS),
		.DIGITS(DIGITS)
	) u_bcd (
		.clk(clk),
		.arst_n(arst_n),
		.load(s_tvalid),
		.mag(mag),
		.neg(neg),
		.kind(s_tuser),
		.ready(s_tready),
		.take(take),
		.ctl(ctl),
		.digits(digits)
	);

	sdaf_emit #(
		.DIGITS(DIGITS)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.digits(digits),
		.take(take),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule

// ===== rtl/core/sdaf_bcd.sv =====
// Serial binary to BCD converter, SDAF_STEP_BITS magnitude bits per cycle.
module sdaf_bcd #(
	parameter int VALUE_BITS = sdaf_pkg::SDAF_VALUE_BITS,
	parameter int DIGITS = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic [VALUE_BITS-2:0]   mag,
	input  logic                    neg,
	input  logic                    kind,
	output logic                    ready,
	input  logic                    take,
	output sdaf_pkg::sdaf_ctl_t     ctl,
	output logic [DIGITS*4-1:0]     digits
);
	import sdaf_pkg::*;

	localparam int MAG_BITS = VALUE_BITS - 1;
	localparam int STEPS    = (MAG_BITS + SDAF_STEP_BITS - 1) / SDAF_STEP_BITS;
	localparam int PAD_BITS = STEPS * SDAF_STEP_BITS;
	localparam int CW       = $clog2(STEPS + 1);

	typedef enum logic [1:0] {B_IDLE, B_RUN, B_DONE} bcd_state_t;

	bcd_state_t          state_q;
	logic [CW-1:0]       cnt_q;
	logic [PAD_BITS-1:0] sh_q;
	logic [DIGITS*4-1:0] bcd_q;
	logic                neg_q;
	logic                kind_q;
	logic [PAD_BITS-1:0] sh_nx;
	logic [DIGITS*4-1:0] bcd_nx;

	// shift-add-3, SDAF_STEP_BITS bits per cycle
	always_comb begin
		logic [DIGITS*4-1:0] b;
		logic [PAD_BITS-1:0] s;
		b = bcd_q;
		s = sh_q;
		for (int j = 0; j < SDAF_STEP_BITS; j++) begin
			for (int i = 0; i < DIGITS; i++) begin
				if (b[i*4 +: 4] >= 4'd5) begin
					b[i*4 +: 4] = b[i*4 +: 4] + 4'd3;
				end
			end
			b = {b[DIGITS*4-2:0], s[PAD_BITS-1]};
			s = {s[PAD_BITS-2:0], 1'b0};
		end
		bcd_nx = b;
		sh_nx  = s;
	end

	assign ready = (state_q == B_IDLE) || (state_q == B_DONE && take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				B_RUN: begin
					sh_q  <= sh_nx;
					bcd_q <= bcd_nx;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(STEPS - 1)) begin
						state_q <= B_DONE;
					end
				end
				B_IDLE, B_DONE: begin
					if (ready && load) begin
						sh_q    <= PAD_BITS'(mag);
						bcd_q   <= '0;
						neg_q   <= neg;
						kind_q  <= kind;
						cnt_q   <= '0;
						state_q <= B_RUN;
					end else if (state_q == B_DONE && take) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign ctl.valid = (state_q == B_DONE);
	assign ctl.neg   = neg_q;
	assign ctl.kind  = kind_q;
	assign digits    = bcd_q;

endmodule

// ===== rtl/core/sdaf_emit.sv =====
// Character sequencer: sign, digits without leading zeros, point, output register.
module sdaf_emit #(
	parameter int DIGITS = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sdaf_pkg::sdaf_ctl_t ctl,
	input  logic [DIGITS*4-1:0] digits,
	output logic                take,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,  // char_code
	output logic                m_tlast   // last_char
);
	import sdaf_pkg::*;

	localparam int IW = $clog2(DIGITS);
	localparam logic [IW-1:0] FRAC_PTR = IW'(SDAF_FRAC_DIGITS);

	typedef enum logic [1:0] {E_IDLE, E_SIGN, E_DIGIT, E_POINT} emit_state_t;

	emit_state_t   phase_q;
	logic [3:0]    dig_q [DIGITS];
	logic [IW-1:0] ptr_q;
	logic          kind_q;
	logic          m_tvalid_q;
	logic [7:0]    m_tdata_q;
	logic          m_tlast_q;
	logic          out_ok;
	logic          word_load;
	logic [IW-1:0] start;

	// first nonzero digit, never below the units (or hundreds-of-hundredths) place
	always_comb begin
		logic [IW-1:0] hi;
		logic [IW-1:0] lo;
		hi = '0;
		lo = (ctl.kind == KIND_HUND) ? FRAC_PTR : '0;
		for (int i = 0; i < DIGITS; i++) begin
			if (digits[i*4 +: 4] != 4'd0) begin
				hi = IW'(i);
			end
		end
		start = (hi > lo) ? hi : lo;
	end

	assign out_ok    = !m_tvalid_q || m_tready;
	assign word_load = out_ok && (phase_q != E_IDLE);
	assign take      = (phase_q == E_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= E_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (word_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (phase_q)
				E_IDLE: begin
					if (ctl.valid) begin
						for (int i = 0; i < DIGITS; i++) begin
							dig_q[i] <= digits[i*4 +: 4];
						end
						kind_q  <= ctl.kind;
						ptr_q   <= start;
						phase_q <= ctl.neg ? E_SIGN : E_DIGIT;
					end
				end
				E_SIGN: begin
					if (out_ok) begin
						m_tdata_q  <= CHAR_MINUS;
						m_tlast_q  <= 1'b0;
						phase_q    <= E_DIGIT;
					end
				end
				E_DIGIT: begin
					if (out_ok) begin
						m_tdata_q  <= CHAR_ZERO | {4'b0, dig_q[ptr_q]};
						if (kind_q == KIND_HUND && ptr_q == FRAC_PTR) begin
							m_tlast_q <= 1'b0;
							ptr_q     <= ptr_q - 1'b1;
							phase_q   <= E_POINT;
						end else if (ptr_q == '0) begin
							m_tlast_q <= 1'b1;
							phase_q   <= E_IDLE;
						end else begin
							m_tlast_q <= 1'b0;
							ptr_q     <= ptr_q - 1'b1;
						end
					end
				end
				E_POINT: begin
					if (out_ok) begin
						m_tdata_q  <= CHAR_POINT;
						m_tlast_q  <= 1'b0;
						phase_q    <= E_DIGIT;
					end
				end
				default: phase_q <= E_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== rtl/core/sdaf_check.sv =====
// Port-level checks for the formatter, bound to the top level.
module sdaf_check #(
	parameter int VALUE_BITS = sdaf_pkg::SDAF_VALUE_BITS
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [((VALUE_BITS+7)/8)*8-1:0] s_tdata,
	input logic                            s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [7:0]                      m_tdata,
	input logic                            m_tlast
);
	import sdaf_pkg::*;

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input word changed while waiting");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE) ||
			m_tdata == CHAR_MINUS || m_tdata == CHAR_POINT))
		else $error("character outside digit, minus and point");

	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE))
		else $error("number ends on a sign or point");

endmodule

bind signed_decimal_ascii_formatter_core sdaf_check #(
	.VALUE_BITS(VALUE_BITS)
) u_sdaf_check (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata(s_tdata),
	.s_tuser(s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the signed decimal ASCII formatter core.
module testbench;
	import sdaf_pkg::*;

	localparam int VB        = SDAF_VALUE_BITS;
	localparam int DW        = ((VB + 7) / 8) * 8;
	localparam int MAX_SHOWN = 10;
	localparam int IDLE_LIMIT = 4000;

	typedef struct {
		logic [7:0] code;
		logic       last;
	} ascii_char_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [DW-1:0] s_tdata;   // value
	logic          s_tuser;   // kind
	logic          m_tvalid;
	logic          m_tready;
	logic [7:0]    m_tdata;   // char_code
	logic          m_tlast;   // last_char

	ascii_char_t pending_chars[$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	bit          no_gaps = 0;

	signed_decimal_ascii_formatter_core #(
		.VALUE_BITS(VB)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// expected characters for one number, appended in output order
	function automatic void format_number(input logic kind, input logic [VB-1:0] raw);
		longint      mag;
		longint      top;
		string       text;
		ascii_char_t c;
		top = (longint'(1) << (VB - 1)) - 1;
		mag = raw[VB-1] ? (longint'(1) << VB) - longint'(raw) : longint'(raw);
		if (mag > top) begin
			mag = top;
		end
		text = "";
		if (raw[VB-1]) begin
			text = "-";
		end
		if (kind == KIND_HUND) begin
			text = {text, $sformatf("%0d.%02d", mag / 100, mag % 100)};
		end else begin
			text = {text, $sformatf("%0d", mag)};
		end
		for (int i = 0; i < text.len(); i++) begin
			c.code = text[i];
			c.last = (i == text.len() - 1);
			pending_chars.push_back(c);
		end
	endfunction

	always @(posedge clk) begin
		ascii_char_t want;
		if (s_tvalid && s_tready) begin
			format_number(s_tuser, s_tdata[VB-1:0]);
		end
		if (m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN) begin
					$display("unexpected word: char %h last %b", m_tdata, m_tlast);
				end
			end else begin
				want = pending_chars.pop_front();
				if (m_tdata !== want.code || m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN) begin
						$display("word mismatch: char exp %h got %h, last exp %b got %b",
							want.code, m_tdata, want.last, m_tlast);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// output side: random stall before each word unless no_gaps is set
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_gaps ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	task automatic send_number(input logic kind, input logic [VB-1:0] value);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		repeat (gap) @(negedge clk);
		s_tdata  = '0;
		s_tdata[VB-1:0] = value;
		s_tuser  = kind;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_chars.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_integer_edges();
		send_number(KIND_INT, VB'(0));
		send_number(KIND_INT, VB'(1));
		send_number(KIND_INT, VB'(-1));
		send_number(KIND_INT, VB'(9));
		send_number(KIND_INT, VB'(10));
		send_number(KIND_INT, VB'(-100));
		send_number(KIND_INT, VB'(12345));
		send_number(KIND_INT, {1'b0, {(VB-1){1'b1}}});
		send_number(KIND_INT, {1'b1, {(VB-2){1'b0}}, 1'b1});
		send_number(KIND_INT, {1'b1, {(VB-1){1'b0}}});
	endtask

	task automatic test_hundredths_edges();
		send_number(KIND_HUND, VB'(0));
		send_number(KIND_HUND, VB'(5));
		send_number(KIND_HUND, VB'(-5));
		send_number(KIND_HUND, VB'(-99));
		send_number(KIND_HUND, VB'(99));
		send_number(KIND_HUND, VB'(100));
		send_number(KIND_HUND, VB'(-100));
		send_number(KIND_HUND, VB'(1203));
		send_number(KIND_HUND, VB'(-1207));
		send_number(KIND_HUND, {1'b0, {(VB-1){1'b1}}});
		send_number(KIND_HUND, {1'b1, {(VB-2){1'b0}}, 1'b1});
		send_number(KIND_HUND, {1'b1, {(VB-1){1'b0}}});
	endtask

	task automatic test_random_numbers(input int count);
		logic [VB-1:0] value;
		int            pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				value = VB'($urandom);
			end else if (pick < 8) begin
				value = VB'($urandom_range(0, 1100));
				if ($urandom_range(0, 1)) begin
					value = -value;
				end
			end else begin
				value = {$urandom_range(0, 1) ? 1'b1 : 1'b0, {(VB-1){1'b0}}};
				value = value[VB-1] ? value + VB'($urandom_range(0, 2))
					: ~value - VB'($urandom_range(0, 2));
			end
			send_number($urandom_range(0, 1) ? KIND_HUND : KIND_INT, value);
		end
	endtask

	// back-to-back burst with no stalls on either side
	task automatic test_full_rate();
		no_gaps = 1;
		test_random_numbers(30);
		no_gaps = 0;
	endtask

	// sender holds off until the output has caught up
	task automatic test_drain_pause();
		test_random_numbers(15);
		wait_drained();
		test_random_numbers(15);
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = KIND_INT;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_integer_edges();
		test_hundredths_edges();
		test_drain_pause();
		test_full_rate();
		test_random_numbers(180);

		wait_drained();
		repeat (40) @(posedge clk);
		if (pending_chars.size() != 0) begin
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/sdaf_pkg.sv
rtl/core/sdaf_bcd.sv
rtl/core/sdaf_emit.sv
rtl/core/signed_decimal_ascii_formatter_core.sv
rtl/core/sdaf_check.sv
dv/testbench.sv
